FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define SFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds across reset
`define SFR_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFR_ASSERT(label, clk, rst_n, prop, msg)
`define SFR_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

FILE: rtl/core/sfr_pkg.sv
// Package for the scanner frame receiver: byte codes, CRC polynomial,
// phase and result-kind enums, result and push structures. No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    // Framing byte codes
    localparam logic [7:0]  BYTE_STX        = 8'h02;
    localparam logic [7:0]  BYTE_REPLY_ADDR = 8'h80;
    localparam logic [7:0]  BYTE_NAK        = 8'h15;
    localparam logic [7:0]  ID_NACK         = 8'h92;
    localparam logic [7:0]  WANTED_ID_RESET = 8'hA0;

    // Shift-xor CRC16 polynomial
    localparam logic [15:0] CRC_POLY        = 16'h8005;

    // Result queue depth (power of two)
    localparam int          FIFO_DEPTH      = 4;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC_LO = 3'd5,
        PH_CRC_HI = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_CRC_FAIL = 3'd2,
        KIND_NAK      = 3'd3,
        KIND_PARTIAL  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_value;
        logic [15:0] data_index;
        logic [7:0]  message_id;
        logic [15:0] data_length;
        logic        id_match;
        logic        nack_reply;
        logic        last_of_run;
    } result_t;

    // Up to two results produced by one byte, r0 first
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

FILE: rtl/core/sfr_parser.sv
// Frame parser: input byte register, hunt/length/data/CRC phase machine and
// result generation. Depends on sfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_parser (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_eob,
    input  logic [7:0]     wanted_id,
    input  logic           space_ok,
    output sfr_pkg::push_t push
);
    import sfr_pkg::*;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;
    logic        advance;

    // Frame state
    phase_t      phase_reg, phase_next, phase_step;
    logic [15:0] crc_reg, crc_next, crc_fed;
    logic [7:0]  prev_reg, prev_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  crclo_reg, crclo_next;

    logic        do_hunt;
    logic        crc_good;

    assign advance  = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || space_ok;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
            in_eob_reg  <= in_eob;
        end
    end

    // CRC step over the current byte and the one before it
    assign crc_fed = {crc_reg[14:0], 1'b0} ^ (crc_reg[15] ? CRC_POLY : 16'h0000)
                   ^ {prev_reg, in_byte_reg};
    assign crc_good = (crclo_reg == crc_reg[7:0]) && (in_byte_reg == crc_reg[15:8]);

    // Next state
    always_comb begin
        phase_step = phase_reg;
        crc_next   = crc_reg;
        prev_next  = prev_reg;
        flen_next  = flen_reg;
        seen_next  = seen_reg;
        id_next    = id_reg;
        crclo_next = crclo_reg;
        do_hunt    = 1'b0;

        case (phase_reg)
            PH_ADDR: begin
                if (in_byte_reg == BYTE_REPLY_ADDR) begin
                    crc_next   = crc_fed;
                    prev_next  = in_byte_reg;
                    phase_step = PH_LEN_LO;
                end else begin
                    do_hunt = 1'b1;
                end
            end
            PH_LEN_LO: begin
                crc_next   = crc_fed;
                prev_next  = in_byte_reg;
                flen_next  = {8'h00, in_byte_reg};
                phase_step = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                crc_next   = crc_fed;
                prev_next  = in_byte_reg;
                flen_next  = {in_byte_reg, flen_reg[7:0]};
                seen_next  = 16'h0000;
                phase_step = ({in_byte_reg, flen_reg[7:0]} == 16'h0000) ? PH_HUNT : PH_DATA;
            end
            PH_DATA: begin
                crc_next  = crc_fed;
                prev_next = in_byte_reg;
                if (seen_reg == 16'h0000) begin
                    id_next   = in_byte_reg;
                    seen_next = 16'h0001;
                end else begin
                    seen_next = seen_reg + 16'h0001;
                end
                if (seen_next == flen_reg) begin
                    phase_step = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                crclo_next = in_byte_reg;
                phase_step = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                phase_step = PH_HUNT;
            end
            default: begin
                do_hunt = 1'b1;
            end
        endcase

        // Hunting: STX opens a frame; ACK, NAK and anything else keep hunting
        if (do_hunt) begin
            phase_step = PH_HUNT;
            if (in_byte_reg == BYTE_STX) begin
                crc_next   = {8'h00, BYTE_STX};
                prev_next  = BYTE_STX;
                flen_next  = 16'h0000;
                seen_next  = 16'h0000;
                id_next    = 8'h00;
                crclo_next = 8'h00;
                phase_step = PH_ADDR;
            end
        end

        phase_next = in_eob_reg ? PH_HUNT : phase_step;
    end

    // Results of this byte
    always_comb begin
        result_t    rd;
        result_t    rp;
        logic       have_data;
        logic       have_part;
        logic       have_other;

        rd         = '0;
        rp         = '0;
        have_data  = 1'b0;
        have_part  = 1'b0;
        have_other = 1'b0;

        if (advance) begin
            // payload byte, or frame verdict, or lone NAK
            if (phase_reg == PH_DATA && seen_reg != 16'h0000) begin
                have_data      = 1'b1;
                rd.kind        = KIND_DATA;
                rd.data_value  = in_byte_reg;
                rd.data_index  = seen_reg - 16'h0001;
                rd.message_id  = id_reg;
                rd.data_length = flen_reg - 16'h0001;
                rd.id_match    = (id_reg == wanted_id);
                rd.nack_reply  = (id_reg == ID_NACK);
            end else if (phase_reg == PH_CRC_HI) begin
                have_other     = 1'b1;
                rd.kind        = crc_good ? KIND_GOOD : KIND_CRC_FAIL;
                rd.message_id  = (seen_reg != 16'h0000) ? id_reg : 8'h00;
                rd.data_length = flen_reg - 16'h0001;
                rd.id_match    = (seen_reg != 16'h0000) && (id_reg == wanted_id);
                rd.nack_reply  = (seen_reg != 16'h0000) && (id_reg == ID_NACK);
            end else if (do_hunt && in_byte_reg == BYTE_NAK) begin
                have_other = 1'b1;
                rd.kind    = KIND_NAK;
            end

            // burst end inside a frame
            if (in_eob_reg && (phase_step inside {[PH_LEN_LO:PH_CRC_HI]})) begin
                have_part     = 1'b1;
                rp.kind       = KIND_PARTIAL;
                rp.data_index = (seen_next != 16'h0000) ? seen_next - 16'h0001 : 16'h0000;
                rp.message_id = (seen_next != 16'h0000) ? id_next : 8'h00;
                rp.data_length = (phase_step inside {[PH_DATA:PH_CRC_HI]}) ?
                                 flen_next - 16'h0001 : 16'h0000;
                rp.id_match   = (seen_next != 16'h0000) && (id_next == wanted_id);
                rp.nack_reply = (seen_next != 16'h0000) && (id_next == ID_NACK);
            end
        end

        push = '0;
        if (have_data || have_other) begin
            push.r0 = rd;
            if (have_part) begin
                push.n  = 2'd2;
                push.r1 = rp;
                push.r1.last_of_run = 1'b1;
            end else begin
                push.n = 2'd1;
                push.r0.last_of_run = 1'b1;
            end
        end else if (have_part) begin
            push.n  = 2'd1;
            push.r0 = rp;
            push.r0.last_of_run = 1'b1;
        end
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            crc_reg   <= 16'h0000;
            prev_reg  <= 8'h00;
            flen_reg  <= 16'h0000;
            seen_reg  <= 16'h0000;
            id_reg    <= 8'h00;
            crclo_reg <= 8'h00;
        end else if (advance) begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            prev_reg  <= prev_next;
            flen_reg  <= flen_next;
            seen_reg  <= seen_next;
            id_reg    <= id_next;
            crclo_reg <= crclo_next;
        end
    end

    `SFR_ASSERT(a_push_needs_advance, aclk, aresetn, (push.n != 2'd0) |-> advance, "results without a processed byte")
    `SFR_ASSERT(a_pair_is_data_partial, aclk, aresetn, (push.n == 2'd2) |-> (push.r0.kind == KIND_DATA && push.r1.kind == KIND_PARTIAL), "two results that are not data then partial")
    `SFR_ASSERT(a_eob_rehunts, aclk, aresetn, (advance && in_eob_reg) |=> (phase_reg == PH_HUNT), "burst end did not return to hunting")

endmodule

FILE: rtl/core/sfr_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on sfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_result_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  sfr_pkg::push_t   push,
    output logic             space_ok,
    output logic             m_valid,
    input  logic             m_ready,
    output sfr_pkg::result_t m_result
);
    import sfr_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    // Room for a pair of results is required before a byte is processed
    assign space_ok = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign m_valid  = (count_reg != '0);
    assign m_result = fifo_mem[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            fifo_mem[wr_ptr_inc] <= push.r1;
        end
    end

    `SFR_ASSERT(a_no_overflow, aclk, aresetn, count_reg <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `SFR_ASSERT(a_push_has_room, aclk, aresetn, (push.n != 2'd0) |-> (count_reg <= CNT_W'(FIFO_DEPTH - 2)), "results pushed without room")
    `SFR_ASSERT_NORST(a_reset_empty, aclk, (!aresetn) |=> (count_reg == '0), "queue not empty after reset")

endmodule

FILE: rtl/core/scanner_frame_receiver_top.sv
// A byte taken is held in the parser's input register; its results are then written
// into the result queue, whose registered count drives m_tvalid.
// Throughput: one byte per cycle; a byte that ends a burst inside a payload gives
// two results, which leave one per transfer through a four-entry result queue.
// Input is held back only while that queue has fewer than two free entries.
// Reset (aresetn low, synchronous) returns to hunting, empties the queue and
// sets wanted_id to 0xA0.
`timescale 1ns / 1ps

module scanner_frame_receiver_top (
    input  logic        aclk,
    input  logic        aresetn,
    // wanted_id register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // end_of_burst
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] data_value, [23:8] data_index,
                                   // [31:24] message_id, [47:32] data_length,
                                   // [48] id_match, [49] nack_reply, [55:50] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last_of_run
);
    import sfr_pkg::*;

    logic [7:0] wanted_id_reg;
    logic       space_ok;
    push_t      push;
    result_t    res;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_id_reg <= WANTED_ID_RESET;
        end else if (cfg_we) begin
            wanted_id_reg <= cfg_wdata;
        end
    end

    sfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_eob    (s_tlast),
        .wanted_id (wanted_id_reg),
        .space_ok  (space_ok),
        .push      (push)
    );

    sfr_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (res)
    );

    // Output packing
    assign m_tdata = {6'b000000, res.nack_reply, res.id_match, res.data_length,
                      res.message_id, res.data_index, res.data_value};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_of_run;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for scanner_frame_receiver_top: directed frames, then random
// well-formed, cut and noisy byte streams checked against an in-bench frame predictor.
// Depends on sfr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module tb_top;
    import sfr_pkg::*;

    localparam logic [7:0] ACK_CODE     = 8'h06;
    localparam int         IDLE_PCT     = 24;
    localparam int         PHASE_ITEMS  = 450;
    localparam int         SETTLE_TICKS = 4;
    localparam int         HOLD_TICKS   = 300;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         N_DIRECTED   = 27;

    // Where a directed byte comes from
    typedef enum logic [1:0] {
        SRC_RAW    = 2'd0,
        SRC_CRC_LO = 2'd1,
        SRC_CRC_HI = 2'd2
    } byte_src_e;

    // One directed byte; typed rows carry their single expected result kind
    typedef struct packed {
        logic [7:0] rx;
        logic       eob;
        byte_src_e  src;
        logic       typed;
        kind_t      t_kind;
    } directed_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Predictor state
    logic [7:0]  exp_wanted_id = WANTED_ID_RESET;
    phase_t      rx_phase      = PH_HUNT;
    logic [15:0] crc_run       = 16'h0000;
    logic [7:0]  crc_prev      = 8'h00;
    logic [15:0] frame_len     = 16'h0000;
    logic [15:0] taken         = 16'h0000;
    logic [7:0]  frame_id      = 8'h00;
    logic [7:0]  crc_lo_got    = 8'h00;

    result_t     frame_events[$];
    result_t     awaited_results[$];
    int unsigned mismatch_count = 0;
    int unsigned items_counted  = 0;
    int unsigned cycle_count    = 0;
    logic        calm        = 1'b0;
    logic        hold_off    = 1'b0;
    logic        start_hold  = 1'b0;

    directed_row_t directed_rows [N_DIRECTED];

    scanner_frame_receiver_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Shift-xor CRC16 over byte pairs
    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] p, logic [7:0] b);
        logic [15:0] s;
        s = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return s ^ {p, b};
    endfunction

    function automatic void crc_take(logic [7:0] b);
        crc_run  = crc_next(crc_run, crc_prev, b);
        crc_prev = b;
    endfunction

    function automatic result_t frame_result(kind_t k, logic [7:0] v, logic [15:0] idx,
                                             bit with_frame);
        result_t r;
        bit      have_id;
        have_id       = with_frame && (taken != 16'h0000);
        r.kind        = k;
        r.data_value  = v;
        r.data_index  = idx;
        r.message_id  = have_id ? frame_id : 8'h00;
        r.data_length = (with_frame && rx_phase >= PH_DATA) ? frame_len - 16'd1 : 16'd0;
        r.id_match    = have_id && (frame_id == exp_wanted_id);
        r.nack_reply  = have_id && (frame_id == ID_NACK);
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Hunting: NAK is reported, STX opens a frame, anything else is dropped
    function automatic void hunt_on(logic [7:0] b);
        if (b == BYTE_NAK) begin
            rx_phase = PH_HUNT;
            frame_events.push_back(frame_result(KIND_NAK, 8'h00, 16'h0000, 1'b0));
        end else if (b == BYTE_STX) begin
            crc_run    = 16'h0000;
            crc_prev   = 8'h00;
            crc_take(b);
            frame_len  = 16'h0000;
            taken      = 16'h0000;
            frame_id   = 8'h00;
            crc_lo_got = 8'h00;
            rx_phase   = PH_ADDR;
        end else begin
            rx_phase = PH_HUNT;
        end
    endfunction

    // Results caused by one received byte; send_byte flags the last one
    function automatic void predict_frame_events(logic [7:0] b, bit eob);
        bit          good;
        logic [15:0] got;
        frame_events.delete();
        case (rx_phase)
            PH_ADDR: begin
                if (b == BYTE_REPLY_ADDR) begin
                    crc_take(b);
                    rx_phase = PH_LEN_LO;
                end else begin
                    hunt_on(b);
                end
            end
            PH_LEN_LO: begin
                crc_take(b);
                frame_len = {8'h00, b};
                rx_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                crc_take(b);
                frame_len[15:8] = b;
                taken    = 16'h0000;
                rx_phase = (frame_len == 16'h0000) ? PH_HUNT : PH_DATA;
            end
            PH_DATA: begin
                crc_take(b);
                if (taken == 16'h0000) begin
                    frame_id = b;
                    taken    = 16'd1;
                end else begin
                    frame_events.push_back(frame_result(KIND_DATA, b, taken - 16'd1, 1'b1));
                    taken = taken + 16'd1;
                end
                if (taken == frame_len)
                    rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_lo_got = b;
                rx_phase   = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                good = (crc_lo_got == crc_run[7:0]) && (b == crc_run[15:8]);
                frame_events.push_back(frame_result(good ? KIND_GOOD : KIND_CRC_FAIL,
                                                    8'h00, 16'h0000, 1'b1));
                rx_phase = PH_HUNT;
            end
            default: begin
                if (b != ACK_CODE)
                    hunt_on(b);
                else
                    rx_phase = PH_HUNT;
            end
        endcase
        // Burst end inside a frame reports what was taken so far
        if (eob) begin
            if (rx_phase >= PH_LEN_LO && rx_phase <= PH_CRC_HI) begin
                got = (taken != 16'h0000) ? taken - 16'd1 : 16'h0000;
                frame_events.push_back(frame_result(KIND_PARTIAL, 8'h00, got, 1'b1));
            end
            rx_phase = PH_HUNT;
        end
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("kind=%0d value=%02h index=%0d id=%02h len=%0d match=%0b nack=%0b last=%0b",
                         r.kind, r.data_value, r.data_index, r.message_id, r.data_length,
                         r.id_match, r.nack_reply, r.last_of_run);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    // Compare one result transfer with the oldest awaited result
    function automatic void check_result();
        result_t got;
        result_t want;
        got.kind        = kind_t'(m_tuser);
        got.data_value  = m_tdata[7:0];
        got.data_index  = m_tdata[23:8];
        got.message_id  = m_tdata[31:24];
        got.data_length = m_tdata[47:32];
        got.id_match    = m_tdata[48];
        got.nack_reply  = m_tdata[49];
        got.last_of_run = m_tlast;
        if (awaited_results.size() == 0) begin
            note_mismatch({"unexpected result: ", describe(got)});
        end else begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.data_value !== want.data_value ||
                got.data_index !== want.data_index || got.message_id !== want.message_id ||
                got.data_length !== want.data_length || got.id_match !== want.id_match ||
                got.nack_reply !== want.nack_reply || got.last_of_run !== want.last_of_run)
                note_mismatch({"expected ", describe(want), " got ", describe(got)});
        end
    endfunction

    // Result side: check each transfer, stall at random or during the hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result();
        m_tready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Long receiver hold-off while the sender keeps offering bytes
    initial begin
        wait (start_hold);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_TICKS) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one byte, wait for its transfer, then queue what it should cause
    task automatic send_byte(input logic [7:0] b, input bit eob, input bit typed,
                             input kind_t t_kind);
        result_t r;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame_events(b, eob);
        if (typed) begin
            r             = '0;
            r.kind        = t_kind;
            r.last_of_run = 1'b1;
            awaited_results.push_back(r);
        end else begin
            foreach (frame_events[i]) begin
                r             = frame_events[i];
                r.last_of_run = (i == frame_events.size() - 1);
                awaited_results.push_back(r);
            end
        end
    endtask

    // Register write once the block has drained
    task automatic write_wanted_id(input logic [7:0] v);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        exp_wanted_id = v;
    endtask

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(5))
            0: return BYTE_STX;
            1: return BYTE_NAK;
            2: return ACK_CODE;
            3: return BYTE_REPLY_ADDR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One random sequence: a frame (whole, cut by a burst end, or bad CRC) or noise
    task automatic run_sequence();
        logic [7:0]  fb[$];
        bit          fe[$];
        int          style;
        int          pick;
        int          cut;
        int          n_lead;
        bit          broken;
        logic [15:0] flen;
        logic [15:0] crc;
        logic [7:0]  prev;
        logic [7:0]  id;
        style = $urandom_range(99);
        if (style < 12) begin
            repeat ($urandom_range(1, 4)) begin
                fb.push_back(pick_noise_byte());
                fe.push_back($urandom_range(9) == 0);
            end
            foreach (fb[i])
                send_byte(fb[i], fe[i], 1'b0, KIND_DATA);
        end else begin
            n_lead = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n_lead)
                send_byte(ACK_CODE, 1'b0, 1'b0, KIND_DATA);
            pick = $urandom_range(99);
            if (pick < 8)
                flen = 16'd0;
            else if (pick < 85)
                flen = 16'($urandom_range(1, 8));
            else if (pick < 95)
                flen = 16'($urandom_range(9, 40));
            else
                flen = 16'($urandom_range(65535));
            broken = (style >= 80) || (flen > 16'd40);
            cut    = broken ? $urandom_range(1, 24) : 32'h7fff_ffff;
            pick   = $urandom_range(99);
            if (pick < 40)
                id = exp_wanted_id;
            else if (pick < 55)
                id = ID_NACK;
            else
                id = 8'($urandom_range(255));
            fb.push_back(BYTE_STX);
            fb.push_back(BYTE_REPLY_ADDR);
            fb.push_back(flen[7:0]);
            fb.push_back(flen[15:8]);
            for (int i = 0; i < flen && fb.size() <= cut; i++)
                fb.push_back((i == 0) ? id : 8'($urandom_range(255)));
            // Whole frame: append its CRC, sometimes with one bit flipped
            if (flen != 16'd0 && fb.size() == flen + 4) begin
                crc  = 16'h0000;
                prev = 8'h00;
                foreach (fb[i]) begin
                    crc  = crc_next(crc, prev, fb[i]);
                    prev = fb[i];
                end
                if ($urandom_range(99) < 15)
                    crc = crc ^ (16'h0001 << $urandom_range(15));
                fb.push_back(crc[7:0]);
                fb.push_back(crc[15:8]);
            end
            while (fb.size() > cut) void'(fb.pop_back());
            foreach (fb[i])
                fe.push_back((i == fb.size() - 1) && (broken || $urandom_range(3) == 0));
            items_counted += fb.size();
            foreach (fb[i])
                send_byte(fb[i], fe[i], 1'b0, KIND_DATA);
        end
    endtask

    // Stimulus
    initial begin
        logic [7:0] wanted_plan [4];
        logic [7:0] b;
        int         target;
        wanted_plan = '{8'h00, 8'hFF, ID_NACK, 8'($urandom_range(255))};
        directed_rows = '{
            // lone NAK after reset, then ACK with burst end while hunting
            '{8'h15, 1'b0, SRC_RAW, 1'b1, KIND_NAK},
            '{8'h06, 1'b1, SRC_RAW, 1'b0, KIND_DATA},
            // STX restarts on a second STX, burst end right after lone STX
            '{8'h02, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h02, 1'b1, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h15, 1'b0, SRC_RAW, 1'b1, KIND_NAK},
            // burst end while reading the length
            '{8'h02, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h80, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h00, 1'b1, SRC_RAW, 1'b1, KIND_PARTIAL},
            // zero length goes back to hunting
            '{8'h02, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h80, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h00, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h00, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            // good frame, wanted id, NAK and ACK as payload
            '{8'h02, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h80, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h03, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h00, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'hA0, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h15, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h06, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h00, 1'b0, SRC_CRC_LO, 1'b0, KIND_DATA},
            '{8'h00, 1'b0, SRC_CRC_HI, 1'b0, KIND_DATA},
            // NACK id frame cut before its CRC: data then partial
            '{8'h02, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h80, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h02, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h00, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'h92, 1'b0, SRC_RAW, 1'b0, KIND_DATA},
            '{8'hFF, 1'b1, SRC_RAW, 1'b0, KIND_DATA}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset value of wanted_id
        foreach (directed_rows[i]) begin
            case (directed_rows[i].src)
                SRC_CRC_LO: b = crc_run[7:0];
                SRC_CRC_HI: b = crc_run[15:8];
                default:    b = directed_rows[i].rx;
            endcase
            send_byte(b, directed_rows[i].eob, directed_rows[i].typed, directed_rows[i].t_kind);
        end

        // Random part, one phase per wanted_id setting; third phase runs without
        // idling and carries the long receiver hold-off
        for (int p = 0; p < 4; p++) begin
            write_wanted_id(wanted_plan[p]);
            calm <= (p == 2);
            if (p == 2)
                start_hold = 1'b1;
            target = items_counted + PHASE_ITEMS;
            while (items_counted < target)
                run_sequence();
            send_byte(ACK_CODE, 1'b1, 1'b0, KIND_DATA);
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
